// ===== hw/rtl/pru_pkg.sv =====
// Shared types, codes and defaults for the pixel replication upscaler.
`timescale 1ns / 1ps

package pru_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_SCALE_DEF = 10;

    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int SCALE_W    = 4;
    localparam int ROW_W      = 11;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_IDLE_TICK = 2'd2
    } status_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [1:0] pad_bytes;
        logic       row_end;
        logic       replay_done;
        status_t    status;
        logic       last;
    } pix_res_t;

endpackage

// ===== hw/rtl/pru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pixel_replication_upscaler.sv =====
// Top level of the nearest-neighbor pixel replication upscaler.
//
//   channel  direction  handshake               payload
//   s_       in         s_valid / s_ready       s_data    (pix_req_t)
//   m_       out        m_valid / m_ready       m_data    (pix_res_t)
//   cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// A pixel or replay request emits effective-scale-factor copies from the copy
// stage, one per cycle when m_ready allows; rejects and empty ticks give one.
// The copy counter of that stage sets the intake rate; the next request enters
// in the cycle its predecessor's final copy moves to the output register.
// Reset is synchronous; the line store is not cleared.
// m_ready low holds the output register and the copy stage, then s_ready drops.
`timescale 1ns / 1ps

module pixel_replication_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_SCALE = MAX_SCALE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_req_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pix_res_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = $clog2(MAX_SCALE + 1);

    logic [SCALE_W-1:0] scale_factor_reg, scale_factor_next;
    logic [ROW_W-1:0]   row_width_reg, row_width_next;

    logic [IDX_W-1:0] write_index_reg, write_index_next;
    logic [IDX_W-1:0] replay_index_reg, replay_index_next;
    logic [CNT_W-1:0] rows_left_reg, rows_left_next;

    logic             b_valid_reg, b_valid_next;
    logic [CNT_W-1:0] b_left_reg, b_left_next;
    logic             b_from_ram_reg, b_from_ram_next;
    logic [PIX_W-1:0] b_px_reg, b_px_next;
    logic             b_at_end_reg, b_at_end_next;
    logic             b_done_reg, b_done_next;
    logic [1:0]       b_pad_reg, b_pad_next;
    status_t          b_status_reg, b_status_next;

    logic     m_valid_reg, m_valid_next;
    pix_res_t m_data_reg, m_data_next;

    logic [CNT_W-1:0] eff_factor;
    logic [WID_W-1:0] eff_width;
    logic [31:0]      row_bytes;
    logic [1:0]       pad_row;
    logic             s_fire, out_free, b_fire, b_fin;
    logic             is_tick, replaying;
    logic             wr_at_end, rp_at_end;
    logic             ram_we, ram_re;
    logic [PIX_W-1:0] in_px, ram_rdata, b_px;

    assign cfg_ready = 1'b1;

    always_comb begin
        scale_factor_next = scale_factor_reg;
        row_width_next    = row_width_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE_FACTOR: scale_factor_next = cfg_wdata[SCALE_W-1:0];
                CFG_ROW_WIDTH:    row_width_next    = cfg_wdata[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (scale_factor_reg == '0) begin
            eff_factor = CNT_W'(1);
        end else if (int'(scale_factor_reg) > MAX_SCALE) begin
            eff_factor = CNT_W'(MAX_SCALE);
        end else begin
            eff_factor = CNT_W'(scale_factor_reg);
        end
        if (row_width_reg == '0) begin
            eff_width = WID_W'(1);
        end else if (int'(row_width_reg) > MAX_WIDTH) begin
            eff_width = WID_W'(MAX_WIDTH);
        end else begin
            eff_width = WID_W'(row_width_reg);
        end
    end

    assign row_bytes = 32'(eff_width) * 32'(eff_factor) * 32'd3;
    assign pad_row   = 2'd0 - row_bytes[1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign b_fire   = b_valid_reg && out_free;
    assign b_fin    = (b_left_reg == CNT_W'(1));
    assign s_ready  = !b_valid_reg || (b_fire && b_fin);
    assign s_fire   = s_valid && s_ready;

    assign is_tick   = (s_data.req_type == REQ_TICK);
    assign replaying = (rows_left_reg != '0);
    assign in_px     = {s_data.red, s_data.green, s_data.blue};
    assign wr_at_end = (WID_W'(write_index_reg) + WID_W'(1)) >= eff_width;
    assign rp_at_end = (WID_W'(replay_index_reg) + WID_W'(1)) >= eff_width;

    assign ram_we = s_fire && !is_tick && !replaying;
    assign ram_re = s_fire && is_tick && replaying;

    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (write_index_reg),
        .wdata (in_px),
        .re    (ram_re),
        .raddr (replay_index_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        write_index_next  = write_index_reg;
        replay_index_next = replay_index_reg;
        rows_left_next    = rows_left_reg;
        b_valid_next      = b_valid_reg;
        b_left_next       = b_left_reg;
        b_from_ram_next   = b_from_ram_reg;
        b_px_next         = b_px_reg;
        b_at_end_next     = b_at_end_reg;
        b_done_next       = b_done_reg;
        b_pad_next        = b_pad_reg;
        b_status_next     = b_status_reg;

        if (b_fire) begin
            b_left_next = b_left_reg - CNT_W'(1);
            if (b_fin) begin
                b_valid_next = 1'b0;
            end
        end

        if (s_fire) begin
            b_valid_next    = 1'b1;
            b_left_next     = eff_factor;
            b_from_ram_next = 1'b0;
            b_px_next       = '0;
            b_at_end_next   = 1'b0;
            b_done_next     = 1'b0;
            b_pad_next      = '0;
            b_status_next   = ST_OK;
            if (!is_tick) begin
                if (replaying) begin
                    b_left_next   = CNT_W'(1);
                    b_status_next = ST_REJECTED;
                end else begin
                    b_px_next     = in_px;
                    b_at_end_next = wr_at_end;
                    b_pad_next    = wr_at_end ? pad_row : 2'd0;
                    if (wr_at_end) begin
                        write_index_next  = '0;
                        replay_index_next = '0;
                        rows_left_next    = eff_factor - CNT_W'(1);
                    end else begin
                        write_index_next = write_index_reg + IDX_W'(1);
                    end
                end
            end else begin
                if (!replaying) begin
                    b_left_next   = CNT_W'(1);
                    b_status_next = ST_IDLE_TICK;
                end else begin
                    b_from_ram_next = 1'b1;
                    b_at_end_next   = rp_at_end;
                    b_pad_next      = rp_at_end ? pad_row : 2'd0;
                    if (rp_at_end) begin
                        replay_index_next = '0;
                        rows_left_next    = rows_left_reg - CNT_W'(1);
                        b_done_next       = (rows_left_reg == CNT_W'(1));
                    end else begin
                        replay_index_next = replay_index_reg + IDX_W'(1);
                    end
                end
            end
        end
    end

    assign b_px = b_from_ram_reg ? ram_rdata : b_px_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (b_fire) begin
            m_valid_next            = 1'b1;
            m_data_next.out_blue    = b_px[7:0];
            m_data_next.out_green   = b_px[15:8];
            m_data_next.out_red     = b_px[23:16];
            m_data_next.pad_bytes   = b_fin ? b_pad_reg : 2'd0;
            m_data_next.row_end     = b_fin && b_at_end_reg;
            m_data_next.replay_done = b_fin && b_done_reg;
            m_data_next.status      = b_status_reg;
            m_data_next.last        = b_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_factor_reg <= SCALE_W'(1);
            row_width_reg    <= ROW_W'(1);
            write_index_reg  <= '0;
            replay_index_reg <= '0;
            rows_left_reg    <= '0;
            b_valid_reg      <= 1'b0;
            b_left_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            scale_factor_reg <= scale_factor_next;
            row_width_reg    <= row_width_next;
            write_index_reg  <= write_index_next;
            replay_index_reg <= replay_index_next;
            rows_left_reg    <= rows_left_next;
            b_valid_reg      <= b_valid_next;
            b_left_reg       <= b_left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_from_ram_reg <= b_from_ram_next;
        b_px_reg       <= b_px_next;
        b_at_end_reg   <= b_at_end_next;
        b_done_reg     <= b_done_next;
        b_pad_reg      <= b_pad_next;
        b_status_reg   <= b_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/pru_checker.sv =====
// Port-level assertions for the pixel replication upscaler, with its bind.
`timescale 1ns / 1ps

module pru_checker
    import pru_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input pix_res_t m_data
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
    else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.last && !m_data.row_end)
    else $error("status result is not a single final result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.row_end |-> (m_data.pad_bytes == 2'd0) && !m_data.replay_done)
    else $error("padding or replay done away from row end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.row_end |-> m_data.last)
    else $error("row end on a copy that is not final");

endmodule

bind pixel_replication_upscaler pru_checker u_pru_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the pixel replication upscaler: directed cases and random rows.
`timescale 1ns / 1ps

module tb_top;
    import pru_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int SCALE_CAP    = 10;
    localparam int RANDOM_ITEMS = 435;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE       = 8;

    class upscale_scoreboard;
        logic [PIX_W-1:0]   line_copy [LINE_DEPTH];
        int unsigned        wr_pos;
        int unsigned        rd_pos;
        int unsigned        rows_left;
        logic [SCALE_W-1:0] scale_reg;
        logic [ROW_W-1:0]   width_reg;
        pix_res_t           pending_copies [$];
        int unsigned        errors;
        int unsigned        checked;

        function new();
            wr_pos    = 0;
            rd_pos    = 0;
            rows_left = 0;
            scale_reg = SCALE_W'(1);
            width_reg = ROW_W'(1);
            errors    = 0;
            checked   = 0;
        endfunction

        function int unsigned factor();
            if (scale_reg == 0) return 1;
            if (scale_reg > SCALE_CAP) return SCALE_CAP;
            return scale_reg;
        endfunction

        function int unsigned width();
            if (width_reg == 0) return 1;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function logic [1:0] row_pad();
            int unsigned bytes;
            bytes = width() * factor() * 3;
            return 2'((4 - bytes % 4) % 4);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SCALE_FACTOR: scale_reg = data[SCALE_W-1:0];
                CFG_ROW_WIDTH:    width_reg = data[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_status(status_t st);
            pix_res_t r;
            r = '0;
            r.status = st;
            r.last = 1'b1;
            pending_copies.push_back(r);
        endfunction

        function void push_copies(logic [PIX_W-1:0] px, bit at_end, bit done);
            pix_res_t r;
            int unsigned n;
            n = factor();
            for (int unsigned i = 0; i < n; i++) begin
                r = '0;
                r.out_blue  = px[7:0];
                r.out_green = px[15:8];
                r.out_red   = px[23:16];
                r.status    = ST_OK;
                if (i + 1 == n) begin
                    r.last        = 1'b1;
                    r.row_end     = at_end;
                    r.replay_done = done;
                    r.pad_bytes   = at_end ? row_pad() : 2'd0;
                end
                pending_copies.push_back(r);
            end
        endfunction

        function void note_request(pix_req_t req);
            int unsigned w;
            logic [PIX_W-1:0] px;
            bit at_end;
            w = width();
            if (req.req_type == REQ_PIXEL) begin
                if (rows_left != 0) begin
                    push_status(ST_REJECTED);
                    return;
                end
                px = {req.red, req.green, req.blue};
                if (wr_pos < LINE_DEPTH) line_copy[wr_pos] = px;
                at_end = (wr_pos + 1 >= w);
                if (at_end) begin
                    wr_pos    = 0;
                    rd_pos    = 0;
                    rows_left = factor() - 1;
                end else begin
                    wr_pos++;
                end
                push_copies(px, at_end, 1'b0);
            end else begin
                if (rows_left == 0) begin
                    push_status(ST_IDLE_TICK);
                    return;
                end
                px = (rd_pos < LINE_DEPTH) ? line_copy[rd_pos] : '0;
                at_end = (rd_pos + 1 >= w);
                if (at_end) begin
                    rd_pos = 0;
                    rows_left--;
                    push_copies(px, 1'b1, rows_left == 0);
                end else begin
                    rd_pos++;
                    push_copies(px, 1'b0, 1'b0);
                end
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v)
                report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got_v,
                                 want_v));
        endtask

        task check_result(pix_res_t got);
            pix_res_t want;
            if (pending_copies.size() == 0) begin
                report($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = pending_copies.pop_front();
            checked++;
            compare_field("out_blue", got.out_blue, want.out_blue);
            compare_field("out_green", got.out_green, want.out_green);
            compare_field("out_red", got.out_red, want.out_red);
            compare_field("pad_bytes", 8'(got.pad_bytes), 8'(want.pad_bytes));
            compare_field("row_end", 8'(got.row_end), 8'(want.row_end));
            compare_field("replay_done", 8'(got.replay_done), 8'(want.replay_done));
            compare_field("status", 8'(got.status), 8'(want.status));
            compare_field("last", 8'(got.last), 8'(want.last));
        endtask

        task check_leftover();
            if (pending_copies.size() != 0)
                report($sformatf("%0d expected results never arrived", pending_copies.size()));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pix_req_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pix_res_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit          calm       = 1'b0;
    int unsigned sent_total = 0;
    int unsigned cfg_writes = 0;
    int unsigned rdy_hold   = 0;
    int unsigned cycles     = 0;

    upscale_scoreboard sb = new();

    pixel_replication_upscaler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] rand_px();
        return PIX_W'($urandom);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (m_ready) begin
            m_ready  <= 1'b0;
            rdy_hold <= pick_gap();
        end else begin
            m_ready  <= 1'b1;
            rdy_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(bit is_tick, logic [PIX_W-1:0] px);
        pix_req_t    req;
        int unsigned gap;
        req.req_type = is_tick ? REQ_TICK : REQ_PIXEL;
        req.blue     = px[7:0];
        req.green    = px[15:8];
        req.red      = px[23:16];
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent_total++;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        forever begin
            @(posedge aclk);
            #1;
            if (sb.pending_copies.size() == 0) break;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] scale_word,
                             logic [CFG_DATA_W-1:0] width_word);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SCALE_FACTOR;
        cfg_wdata <= scale_word;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_ROW_WIDTH;
        cfg_wdata <= width_word;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes += 2;
        @(posedge aclk);
    endtask

    task automatic random_rows();
        logic [CFG_DATA_W-1:0] scale_word;
        logic [CFG_DATA_W-1:0] width_word;
        int unsigned f, w, rows, n, cut;
        case ($urandom_range(0, 9))
            0:       width_word = '0;
            1:       width_word = CFG_DATA_W'($urandom_range(9, 40));
            default: width_word = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       scale_word = '0;
            1:       scale_word = CFG_DATA_W'($urandom_range(10, 15)
                                              | ($urandom_range(0, 127) << SCALE_W));
            2:       scale_word = CFG_DATA_W'(SCALE_CAP);
            default: scale_word = CFG_DATA_W'($urandom_range(1, 4));
        endcase
        if (width_word > 8) scale_word = CFG_DATA_W'($urandom_range(1, 3));
        calm = ($urandom_range(0, 3) == 0);
        configure(scale_word, width_word);
        f = sb.factor();
        w = sb.width();
        rows = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
            n = (r == 0 && sb.wr_pos < w) ? w - sb.wr_pos : (r == 0 ? 1 : w);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
            for (int k = 0; k < cut; k++) begin
                if ($urandom_range(0, 15) == 0) send_request(1'b1, rand_px());
                send_request(1'b0, rand_px());
            end
            if (cut != n) break;
            for (int t = 0; t < (f - 1) * w; t++) begin
                if ($urandom_range(0, 15) == 0) send_request(1'b0, rand_px());
                send_request(1'b1, rand_px());
            end
            if ($urandom_range(0, 5) == 0) send_request(1'b1, rand_px());
        end
        wait_idle();
    endtask

    initial begin
        int unsigned random_base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(1'b1, rand_px());
        wait_idle();
        configure(CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_request(1'b0, 24'h000000);
        wait_idle();
        configure(11'h7FF, CFG_DATA_W'(1));
        send_request(1'b0, 24'hFFFFFF);
        send_request(1'b0, 24'h00FF00);
        repeat (SCALE_CAP) send_request(1'b1, rand_px());
        wait_idle();
        configure(CFG_DATA_W'(2), CFG_DATA_W'(5));
        send_request(1'b0, 24'hFF0000);
        send_request(1'b0, 24'h0000FF);
        wait_idle();
        configure(CFG_DATA_W'(3), CFG_DATA_W'(2));
        send_request(1'b0, 24'h5AA55A);
        repeat (4) send_request(1'b1, rand_px());
        wait_idle();

        configure(CFG_DATA_W'(1), 11'h7FF);
        repeat (3) send_request(1'b0, rand_px());
        wait_idle();
        configure(CFG_DATA_W'(1), CFG_DATA_W'(1));
        send_request(1'b0, rand_px());
        wait_idle();

        random_base = sent_total;
        while (sent_total - random_base < RANDOM_ITEMS) random_rows();
        calm = 1'b0;
        wait_idle();

        sb.check_leftover();
        $display("Sent %0d requests (directed cases, random rows), %0d results checked.",
                 sent_total, sb.checked);
        $display("Wrote %0d registers, factors 0 to 15 and widths 0 to 40 plus 2047 included.",
                 cfg_writes);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pru_pkg.sv
hw/rtl/pru_ram.sv
hw/rtl/pixel_replication_upscaler.sv
hw/rtl/pru_checker.sv
tb/sv/tb_top.sv
